@@ rtl/pdo_bit_map_pack_unpack_defines.svh @@
// assertion helpers for the pdo bit map block
`ifndef PDO_BIT_MAP_PACK_UNPACK_DEFINES_SVH
`define PDO_BIT_MAP_PACK_UNPACK_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PDO_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PDO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pdo_bmpu_pkg.sv @@
package pdo_bmpu_pkg;

    // parameter defaults
    localparam int MAX_ENTRIES_DEF = 8;
    localparam int FRAME_BITS_DEF  = 64;

    // field widths
    localparam int DATA_W    = 64;
    localparam int OFF_W     = 7;
    localparam int SIZE_W    = 8;
    localparam int CNT_W     = 4;
    localparam int ENT_W     = 3;
    localparam int KIND_W    = 2;
    localparam int LEN_W     = 4;
    localparam int CFG_IDX_W = 2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_FRAME = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIELD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    // commands
    localparam logic CMD_PACK   = 1'b0;
    localparam logic CMD_UNPACK = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_SIZES = 2'd1;

    // request to the shared field unit
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [OFF_W-1:0]  offset;
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  limit;
    } field_req_t;

    // answer of the shared field unit
    typedef struct packed {
        logic              fits;
        logic [DATA_W-1:0] extract;
        logic [DATA_W-1:0] insert;
        logic [OFF_W-1:0]  offset_next;
    } field_rsp_t;

    // size in bits of one mapping entry
    function automatic logic [SIZE_W-1:0] size_of(input logic [DATA_W-1:0] sizes,
                                                  input logic [ENT_W-1:0] idx);
        return sizes[idx*SIZE_W +: SIZE_W];
    endfunction

    // bytes covering a bit count, rounded up
    function automatic logic [LEN_W-1:0] byte_len(input logic [OFF_W-1:0] bits);
        logic [OFF_W:0] sum;
        sum = {1'b0, bits} + (OFF_W+1)'(7);
        return sum[LEN_W+2:3];
    endfunction

endpackage

@@ rtl/pdo_bmpu_field_unit.sv @@
module pdo_bmpu_field_unit (
    input  pdo_bmpu_pkg::field_req_t req,
    output pdo_bmpu_pkg::field_rsp_t rsp
);
    import pdo_bmpu_pkg::*;

    logic [DATA_W-1:0] mask;
    logic [OFF_W+1:0]  end_bit;
    logic [5:0]        shamt;

    // low-bits mask for the field size
    assign mask = (req.size >= SIZE_W'(DATA_W)) ? {DATA_W{1'b1}}
                : ~({DATA_W{1'b1}} << req.size[5:0]);

    // fit check against the usable frame length
    assign end_bit = {2'b00, req.offset} + {1'b0, req.size};
    assign shamt   = req.offset[5:0];

    always_comb
    begin
        rsp.fits        = (req.size != '0) && (end_bit <= {2'b00, req.limit});
        rsp.offset_next = end_bit[OFF_W-1:0];
        rsp.extract     = (req.data >> shamt) & mask;
        rsp.insert      = (req.data & mask) << shamt;
    end

endmodule

@@ rtl/pdo_bit_map_pack_unpack.sv @@
// pack item: accepted in idle, worked in the pack state once the output is free, result registered;
// a missing placed value gives an error result. unpack item: one field per cycle while the output
// is free, through the shared shift/mask unit; no new item is taken until the last field is out.
// a pack item that does not close its frame, or an unpack item with no entries, gives no result.
// async active-low reset clears config, control and pack state and output valid; no clearing pass.
`include "pdo_bit_map_pack_unpack_defines.svh"

module pdo_bit_map_pack_unpack #(
    parameter int MAX_ENTRIES = pdo_bmpu_pkg::MAX_ENTRIES_DEF,
    parameter int FRAME_BITS  = pdo_bmpu_pkg::FRAME_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pdo_bmpu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pdo_bmpu_pkg::DATA_W-1:0]      cfg_data,
    // input item channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 cmd,
    input  logic [pdo_bmpu_pkg::DATA_W-1:0]      item_data,
    input  logic [pdo_bmpu_pkg::CNT_W-1:0]       rx_length,
    input  logic                                 value_missing,
    // result item channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [pdo_bmpu_pkg::KIND_W-1:0]      kind,
    output logic [pdo_bmpu_pkg::DATA_W-1:0]      result_data,
    output logic [pdo_bmpu_pkg::LEN_W-1:0]       byte_length,
    output logic [pdo_bmpu_pkg::ENT_W-1:0]       entry_number,
    output logic                                 entry_fits,
    output logic                                 last
);
    import pdo_bmpu_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_ENTRIES);
    localparam logic [OFF_W-1:0] FRAME_LIM = OFF_W'(FRAME_BITS);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PACK   = 2'd1;
    localparam logic [1:0] ST_UNPACK = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  entry_count_reg, entry_count_next;
    logic [DATA_W-1:0] entry_sizes_reg, entry_sizes_next;
    logic [OFF_W-1:0]  bit_offset_reg, bit_offset_next;
    logic [DATA_W-1:0] payload_acc_reg, payload_acc_next;
    logic [CNT_W-1:0]  next_entry_reg, next_entry_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic              missing_reg, missing_next;
    logic [OFF_W-1:0]  limit_reg, limit_next;
    logic [ENT_W-1:0]  ent_reg, ent_next;
    logic [OFF_W-1:0]  off_u_reg, off_u_next;
    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] kind_reg;
    logic [DATA_W-1:0] result_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [ENT_W-1:0]  entno_reg;
    logic              fits_reg;
    logic              last_reg;

    logic              emit;
    logic [KIND_W-1:0] emit_kind;
    logic [DATA_W-1:0] emit_data;
    logic [LEN_W-1:0]  emit_len;
    logic              emit_fits;
    logic              emit_last;

    logic              in_fire;
    logic              cfg_fire;
    logic              out_free;
    logic [CNT_W-1:0]  count_sat;
    logic [CNT_W-1:0]  rx_sat;
    logic [OFF_W-1:0]  rx_bits;
    logic [OFF_W-1:0]  rx_limit;
    logic [CNT_W-1:0]  ne_inc;
    logic [DATA_W-1:0] acc_after;
    logic [OFF_W-1:0]  off_after;
    logic              unpack_last;

    field_req_t        unit_req;
    field_rsp_t        unit_rsp;

    // handshakes
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid & in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // entries in use and usable frame length
    assign count_sat = (entry_count_reg > MAX_CNT) ? MAX_CNT : entry_count_reg;
    assign rx_sat    = (rx_length > CNT_W'(8)) ? CNT_W'(8) : rx_length;
    assign rx_bits   = {rx_sat, 3'b000};
    assign rx_limit  = (rx_bits > FRAME_LIM) ? FRAME_LIM : rx_bits;

    // operands of the shared field unit
    always_comb
    begin
        unit_req.data = data_reg;
        if (state_reg == ST_UNPACK)
        begin
            unit_req.offset = off_u_reg;
            unit_req.size   = size_of(entry_sizes_reg, ent_reg);
            unit_req.limit  = limit_reg;
        end
        else
        begin
            unit_req.offset = bit_offset_reg;
            unit_req.size   = size_of(entry_sizes_reg, next_entry_reg[ENT_W-1:0]);
            unit_req.limit  = FRAME_LIM;
        end
    end

    pdo_bmpu_field_unit u_field (
        .req (unit_req),
        .rsp (unit_rsp)
    );

    // pack step results
    assign ne_inc      = next_entry_reg + CNT_W'(1);
    assign acc_after   = unit_rsp.fits ? (payload_acc_reg | unit_rsp.insert) : payload_acc_reg;
    assign off_after   = unit_rsp.fits ? unit_rsp.offset_next : bit_offset_reg;
    assign unpack_last = ({1'b0, ent_reg} + CNT_W'(1)) == count_sat;

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        entry_sizes_next = entry_sizes_reg;
        bit_offset_next  = bit_offset_reg;
        payload_acc_next = payload_acc_reg;
        next_entry_next  = next_entry_reg;
        data_next        = data_reg;
        missing_next     = missing_reg;
        limit_next       = limit_reg;
        ent_next         = ent_reg;
        off_u_next       = off_u_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        emit             = 1'b0;
        emit_kind        = KIND_FRAME;
        emit_data        = '0;
        emit_len         = '0;
        emit_fits        = 1'b0;
        emit_last        = 1'b1;

        // register writes
        if (cfg_fire)
        begin
            case (cfg_index)
                REG_ENTRY_COUNT: entry_count_next = cfg_data[CNT_W-1:0];
                REG_ENTRY_SIZES: entry_sizes_next = cfg_data;
                default:         ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    data_next    = item_data;
                    missing_next = value_missing;
                    limit_next   = rx_limit;
                    ent_next     = '0;
                    off_u_next   = '0;
                    if (cmd == CMD_PACK)
                        state_next = ST_PACK;
                    else if (count_sat != '0)
                        state_next = ST_UNPACK;
                end
            end

            ST_PACK:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                    if (count_sat == '0)
                    begin
                        // no entries: empty or pending frame closes at once
                        emit      = 1'b1;
                        emit_data = payload_acc_reg;
                        emit_len  = byte_len(bit_offset_reg);
                    end
                    else if (unit_rsp.fits && missing_reg)
                    begin
                        // placed value could not be fetched
                        emit      = 1'b1;
                        emit_kind = KIND_ERROR;
                    end
                    else if (ne_inc < count_sat)
                    begin
                        payload_acc_next = acc_after;
                        bit_offset_next  = off_after;
                        next_entry_next  = ne_inc;
                    end
                    else
                    begin
                        emit      = 1'b1;
                        emit_data = acc_after;
                        emit_len  = byte_len(off_after);
                    end
                    if (emit)
                    begin
                        payload_acc_next = '0;
                        bit_offset_next  = '0;
                        next_entry_next  = '0;
                    end
                end
            end

            ST_UNPACK:
            begin
                if (out_free)
                begin
                    // one mapping entry per cycle while the output is free
                    emit      = 1'b1;
                    emit_kind = KIND_FIELD;
                    emit_data = unit_rsp.fits ? unit_rsp.extract : '0;
                    emit_fits = unit_rsp.fits;
                    emit_last = unpack_last;
                    if (unit_rsp.fits)
                        off_u_next = unit_rsp.offset_next;
                    ent_next = ent_reg + ENT_W'(1);
                    if (unpack_last)
                        state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
            out_valid_next = 1'b1;
    end

    // control and pack state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            entry_sizes_reg <= '0;
            bit_offset_reg  <= '0;
            payload_acc_reg <= '0;
            next_entry_reg  <= '0;
            ent_reg         <= '0;
            off_u_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            entry_sizes_reg <= entry_sizes_next;
            bit_offset_reg  <= bit_offset_next;
            payload_acc_reg <= payload_acc_next;
            next_entry_reg  <= next_entry_next;
            ent_reg         <= ent_next;
            off_u_reg       <= off_u_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        data_reg    <= data_next;
        missing_reg <= missing_next;
        limit_reg   <= limit_next;
        if (emit)
        begin
            kind_reg   <= emit_kind;
            result_reg <= emit_data;
            len_reg    <= emit_len;
            entno_reg  <= (emit_kind == KIND_FIELD) ? ent_reg : '0;
            fits_reg   <= emit_fits;
            last_reg   <= emit_last;
        end
    end

    // result ports
    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign result_data  = result_reg;
    assign byte_length  = len_reg;
    assign entry_number = entno_reg;
    assign entry_fits   = fits_reg;
    assign last         = last_reg;

    // checks
    `PDO_ASSERT_SAME(a_kind_last, out_valid_reg && (kind_reg == KIND_FRAME || kind_reg == KIND_ERROR), last_reg, "frame or error result without last")
    `PDO_ASSERT_NEXT(a_unpack_done, state_reg == ST_UNPACK && out_free && unpack_last, state_reg == ST_IDLE && out_valid_reg && last_reg, "unpack did not end on its last field")
    `PDO_ASSERT_NEXT(a_pack_clear, state_reg == ST_PACK && out_free && emit, bit_offset_reg == '0 && next_entry_reg == '0 && payload_acc_reg == '0, "pack state not cleared after frame close")
    `PDO_ASSERT_SAME(a_offset_range, state_reg != ST_IDLE, bit_offset_reg <= FRAME_LIM && off_u_reg <= FRAME_LIM, "bit offset beyond frame")

endmodule
